// ===== rtl/ppsq_pkg.sv =====
package ppsq_pkg;

  localparam int unsigned InTdataW  = 272;
  localparam int unsigned OutTdataW = 32;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 64;

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    REG_REFERENCE_MAX_AGE  = 3'd0,
    REG_FLAG_INVALID_MASK  = 3'd1,
    REG_NOMINAL_INTERVAL   = 3'd2,
    REG_INTERVAL_TOLERANCE = 3'd3,
    REG_METADATA_MAX_AGE   = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    CAD_UNAVAILABLE = 3'd0,
    CAD_MISSING     = 3'd1,
    CAD_INVALID     = 3'd2,
    CAD_DUPLICATE   = 3'd3,
    CAD_SHORT       = 3'd4,
    CAD_LONG        = 3'd5,
    CAD_VALID       = 3'd6
  } cadence_t;

  typedef enum logic [1:0] {
    PATH_UNAVAILABLE = 2'd0,
    PATH_SEQ_GAP     = 2'd1,
    PATH_INVALID     = 2'd2,
    PATH_VALID       = 2'd3
  } path_t;

  typedef enum logic [1:0] {
    FRESH_MISSING = 2'd0,
    FRESH_STALE   = 2'd1,
    FRESH_CURRENT = 2'd2
  } fresh_t;

  localparam logic [2:0] AUTH_QUALIFIED = 3'd0;
  localparam logic [2:0] AUTH_HOLDOVER  = 3'd1;
  localparam logic [2:0] AUTH_ANTENNA   = 3'd3;
  localparam logic [2:0] AUTH_UNKNOWN   = 3'd6;
  localparam logic [2:0] AUTH_RESERVED  = 3'd7;

  localparam logic [1:0] UTC_VALID   = 2'd0;
  localparam logic [1:0] UTC_BAD     = 2'd1;
  localparam logic [1:0] UTC_UNKNOWN = 2'd3;

  typedef enum logic [3:0] {
    QUAL_PATH_INVALID     = 4'd0,
    QUAL_UNKNOWN          = 4'd1,
    QUAL_UNQUALIFIED      = 4'd2,
    QUAL_META_STALE       = 4'd3,
    QUAL_AUTHORITY_UNKNOWN = 4'd4,
    QUAL_ANTENNA_ALARM    = 4'd5,
    QUAL_HOLDOVER         = 4'd6,
    QUAL_UTC_BAD          = 4'd7,
    QUAL_QUALIFIED        = 4'd8
  } qual_t;

  // Reason mask bit positions.
  localparam int unsigned RsRefUnavail   = 0;
  localparam int unsigned RsMissing      = 1;
  localparam int unsigned RsContUnavail  = 2;
  localparam int unsigned RsSeqNonmono   = 3;
  localparam int unsigned RsFlagInvalid  = 4;
  localparam int unsigned RsDuplicate    = 5;
  localparam int unsigned RsShort        = 6;
  localparam int unsigned RsLong         = 7;
  localparam int unsigned RsCadValid     = 8;
  localparam int unsigned RsMetaMissing  = 9;
  localparam int unsigned RsMetaStale    = 10;
  localparam int unsigned RsAntenna      = 11;
  localparam int unsigned RsHoldover     = 12;
  localparam int unsigned RsRxQualified  = 13;
  localparam int unsigned RsAuthUnknown  = 14;
  localparam int unsigned ReasonW        = 15;

  typedef struct packed {
    logic [63:0] reference_max_age;
    logic [31:0] flag_invalid_mask;
    logic [31:0] nominal_interval;
    logic [31:0] interval_tolerance;
    logic [63:0] metadata_max_age;
  } cfg_t;

  typedef struct packed {
    logic        cur_present;
    logic [63:0] cur_ticks;
    logic [31:0] cur_seq;
    logic [31:0] cur_flags;
    logic [63:0] time_now;
    logic        meta_present;
    logic [2:0]  meta_authority;
    logic [1:0]  meta_utc;
    logic [63:0] meta_ticks;
    logic        antenna_alarm;
    logic        fix_holdover;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] stamp;
    logic [31:0] number;
  } prev_t;

  typedef struct packed {
    cadence_t             cadence;
    path_t                capture_path;
    logic [2:0]           authority_out;
    logic [1:0]           utc_out;
    fresh_t               freshness;
    qual_t                qualification;
    logic [ReasonW-1:0]   reasons;
  } result_t;

endpackage

// ===== rtl/ppsq_eval.sv =====
module ppsq_eval
  import ppsq_pkg::*;
(
  input  item_t   item,
  input  cfg_t    cfg,
  input  prev_t   prev,
  output result_t res
);

  logic [64:0]        age_diff;
  logic               cap_missing;
  logic [63:0]        win_lo;
  logic [63:0]        win_hi;
  logic [63:0]        interval;
  logic [64:0]        meta_diff;
  logic               meta_stale;
  logic [2:0]         auth;
  cadence_t           cad;
  path_t              path;
  fresh_t             fresh;
  qual_t              qual;
  logic [ReasonW-1:0] rs;

  // Bit 64 of age_diff and meta_diff is the borrow, set when the subtrahend is larger.
  assign age_diff    = {1'b0, item.time_now} - {1'b0, item.cur_ticks};
  assign cap_missing = !age_diff[64] && (age_diff[63:0] > cfg.reference_max_age);

  assign win_lo   = {32'd0, cfg.nominal_interval} - {32'd0, cfg.interval_tolerance};
  assign win_hi   = {32'd0, cfg.nominal_interval} + {32'd0, cfg.interval_tolerance};
  assign interval = item.cur_ticks - prev.stamp;

  assign meta_diff  = {1'b0, item.time_now} - {1'b0, item.meta_ticks};
  assign meta_stale = meta_diff[64] || (meta_diff[63:0] > cfg.metadata_max_age);

  assign auth = (item.meta_authority == AUTH_RESERVED) ? AUTH_UNKNOWN : item.meta_authority;

  always_comb begin
    cad   = CAD_UNAVAILABLE;
    path  = PATH_UNAVAILABLE;
    fresh = FRESH_MISSING;
    rs    = '0;

    if (!item.cur_present) begin
      rs[RsRefUnavail] = 1'b1;
    end else if (cap_missing) begin
      cad = CAD_MISSING;
      rs[RsMissing] = 1'b1;
    end else if (!prev.valid) begin
      rs[RsContUnavail] = 1'b1;
    end else if (item.cur_seq <= prev.number) begin
      cad  = CAD_INVALID;
      path = PATH_SEQ_GAP;
      rs[RsSeqNonmono] = 1'b1;
    end else if ((item.cur_flags & cfg.flag_invalid_mask) != '0) begin
      cad  = CAD_INVALID;
      path = PATH_INVALID;
      rs[RsFlagInvalid] = 1'b1;
    end else begin
      path = PATH_VALID;
      if (item.cur_ticks <= prev.stamp) begin
        cad = CAD_DUPLICATE;
        rs[RsDuplicate] = 1'b1;
      end else if (interval < win_lo) begin
        cad = CAD_SHORT;
        rs[RsShort] = 1'b1;
      end else if (interval > win_hi) begin
        cad = CAD_LONG;
        rs[RsLong] = 1'b1;
      end else begin
        cad = CAD_VALID;
        rs[RsCadValid] = 1'b1;
      end
    end

    if (!item.meta_present) begin
      rs[RsMetaMissing] = 1'b1;
    end else if (meta_stale) begin
      fresh = FRESH_STALE;
      rs[RsMetaStale] = 1'b1;
    end else begin
      fresh = FRESH_CURRENT;
    end

    if (path == PATH_SEQ_GAP || path == PATH_INVALID) begin
      qual = QUAL_PATH_INVALID;
    end else if (cad != CAD_VALID) begin
      qual = (cad == CAD_UNAVAILABLE) ? QUAL_UNKNOWN : QUAL_UNQUALIFIED;
    end else if (fresh != FRESH_CURRENT) begin
      qual = (fresh == FRESH_STALE) ? QUAL_META_STALE : QUAL_AUTHORITY_UNKNOWN;
    end else if (auth == AUTH_ANTENNA || item.antenna_alarm) begin
      qual = QUAL_ANTENNA_ALARM;
      rs[RsAntenna] = 1'b1;
    end else if (auth == AUTH_HOLDOVER || item.fix_holdover) begin
      qual = QUAL_HOLDOVER;
      rs[RsHoldover] = 1'b1;
    end else if (item.meta_utc == UTC_BAD) begin
      qual = QUAL_UTC_BAD;
    end else if (auth == AUTH_QUALIFIED && item.meta_utc == UTC_VALID) begin
      qual = QUAL_QUALIFIED;
      rs[RsRxQualified] = 1'b1;
    end else begin
      qual = QUAL_AUTHORITY_UNKNOWN;
      rs[RsAuthUnknown] = 1'b1;
    end
  end

  assign res.cadence       = cad;
  assign res.capture_path  = path;
  assign res.authority_out = item.meta_present ? auth : AUTH_UNKNOWN;
  assign res.utc_out       = item.meta_present ? item.meta_utc : UTC_UNKNOWN;
  assign res.freshness     = fresh;
  assign res.qualification = qual;
  assign res.reasons       = rs;

endmodule

// ===== rtl/pps_reference_qualifier_core.sv =====
// Each capture passes an input register and then a result register on its way to
// the output. Throughput: one capture per clock cycle while the result stream is not
// stalled; the evaluation stage reads the previous capture, which is updated at the
// same edge that loads the result register.
// Reset (rst_n low at a rising edge) empties both stages, zeroes all five
// configuration registers and forgets the previous capture.
module pps_reference_qualifier_core
  import ppsq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Input capture stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // From bit 0: cur_present, cur_ticks, cur_seq, cur_flags, time_now, meta_present,
  // meta_authority, meta_utc, meta_ticks, antenna alarm, fix_holdover, zero fill.
  input  logic [InTdataW-1:0]  in_tdata,
  // Result stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // From bit 0: cadence, capture_path, authority_out, utc_out, freshness,
  // qualification, reasons, zero fill.
  output logic [OutTdataW-1:0] out_tdata,
  // Configuration write port.
  input  logic                 cfg_wr_en,
  input  logic [CfgAddrW-1:0]  cfg_addr,
  input  logic [CfgDataW-1:0]  cfg_wdata
);

  cfg_t    cfg_r;
  prev_t   prev_r;
  item_t   in_item;
  item_t   stage_r;
  logic    stage_vld_r;
  result_t res;
  result_t out_r;
  logic    out_vld_r;
  logic    stage_adv;
  logic    in_fire;

  // Unpack the input transaction.
  assign in_item.cur_present    = in_tdata[0];
  assign in_item.cur_ticks      = in_tdata[64:1];
  assign in_item.cur_seq        = in_tdata[96:65];
  assign in_item.cur_flags      = in_tdata[128:97];
  assign in_item.time_now       = in_tdata[192:129];
  assign in_item.meta_present   = in_tdata[193];
  assign in_item.meta_authority = in_tdata[196:194];
  assign in_item.meta_utc       = in_tdata[198:197];
  assign in_item.meta_ticks     = in_tdata[262:199];
  assign in_item.antenna_alarm  = in_tdata[263];
  assign in_item.fix_holdover   = in_tdata[264];

  // Configuration registers. Writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_REFERENCE_MAX_AGE:  cfg_r.reference_max_age  <= cfg_wdata;
        REG_FLAG_INVALID_MASK:  cfg_r.flag_invalid_mask  <= cfg_wdata[31:0];
        REG_NOMINAL_INTERVAL:   cfg_r.nominal_interval   <= cfg_wdata[31:0];
        REG_INTERVAL_TOLERANCE: cfg_r.interval_tolerance <= cfg_wdata[31:0];
        REG_METADATA_MAX_AGE:   cfg_r.metadata_max_age   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The evaluation stage moves forward whenever the result register is free or
  // being drained, so a new capture enters while an older result still waits.
  assign stage_adv = stage_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !stage_vld_r || stage_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else if (in_tready) begin
      stage_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_r <= in_item;
    end
  end

  ppsq_eval u_eval (
    .item (stage_r),
    .cfg  (cfg_r),
    .prev (prev_r),
    .res  (res)
  );

  // Every evaluated capture replaces the stored one, whatever its outcome.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (stage_adv) begin
      prev_r.valid  <= stage_r.cur_present;
      prev_r.stamp  <= stage_r.cur_ticks;
      prev_r.number <= stage_r.cur_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stage_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_r.reasons, out_r.qualification, out_r.freshness,
                       out_r.utc_out, out_r.authority_out, out_r.capture_path,
                       out_r.cadence};

endmodule
